@@ design/pmwd_pkg.sv @@
// ============================================================================
// pmwd_pkg: shared constants of the particle mesh weight deposit
// Fixed-point formats, field widths and register codes used by the block
// and its port checker.
// ============================================================================
`default_nettype none

package pmwd_pkg;

    // Fixed-point format and mesh limits.
    localparam int FRAC_BITS  = 16;
    localparam int MAX_MESH   = 1024;
    localparam int POS_W      = 26;
    localparam int INT_W      = POS_W - FRAC_BITS;
    localparam int CELL_W     = $clog2(MAX_MESH);
    localparam int MESH_W     = CELL_W + 1;
    localparam int VAL_W      = 32;
    localparam int WT_W       = FRAC_BITS + 1;
    localparam int PROD_W     = 2 * WT_W;

    // Stencil geometry.
    localparam int NPTS       = 3;
    localparam int PT_W       = $clog2(NPTS);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int SCHEME_W   = 2;
    localparam int MESH_MIN   = 2;
    localparam int MESH_RESET = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MESH_SIZE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCHEME_ORDER = CFG_IDX_W'(1);
    localparam logic [SCHEME_W-1:0]  SCHEME_TSC       = SCHEME_W'(2);

    // Weight constants in Q1.FRAC_BITS, and 3/4 in Q2.(2*FRAC_BITS).
    localparam logic [WT_W-1:0]   W_ONE        = WT_W'(1 << FRAC_BITS);
    localparam logic [WT_W-1:0]   W_HALF       = WT_W'(1 << (FRAC_BITS - 1));
    localparam logic [WT_W-1:0]   W_THREE_HALF = WT_W'(3 << (FRAC_BITS - 1));
    localparam logic [PROD_W-1:0] TSC_PEAK     = PROD_W'(64'd3 << (2 * FRAC_BITS - 2));

endpackage

`default_nettype wire

@@ design/particle_mesh_weight_deposit.sv @@
// ============================================================================
// particle_mesh_weight_deposit: cloud in cell / triangular shaped cloud
// Turns one particle into the weighted contributions to its 2x2x2 or 3x3x3
// stencil of mesh cells, one cell per transfer on the result channel.
// ============================================================================
`default_nettype none

// The block delivers one stencil cell per clock on its result channel while
// i_ready is high, so a cloud in cell particle yields 8 cells and a
// triangular shaped cloud particle 27; the stencil walker, which hands out
// one cell per cycle while not stalled, sets that rate. Particles enter an
// 11-stage setup pipeline (an input stage, integer reduction mod the mesh
// size, two restoring steps per stage, then distance, minimum image, weight
// zone, square and weight stages) and are taken by the walker as soon as
// the previous particle's last cell leaves it, so the result channel runs
// without gaps while the next particle is ready. The setup pipeline holds
// up to eleven particles while the output stalls. Each cell then passes
// five result stages (select, wx*wy, times wz, value times weight, sign)
// before it reaches the result channel. Configuration writes are taken in
// every cycle; they must only be issued while no particle is in flight. The
// mesh size is clamped into 2..MAX_MESH on write and any scheme code other
// than the triangular shaped cloud code selects cloud in cell.
module particle_mesh_weight_deposit (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // Particle channel.
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire  [pmwd_pkg::POS_W-1:0]           i_pos_x,
    input  wire  [pmwd_pkg::POS_W-1:0]           i_pos_y,
    input  wire  [pmwd_pkg::POS_W-1:0]           i_pos_z,
    input  wire  signed [pmwd_pkg::VAL_W-1:0]    i_deposit_value,
    // Cell result channel.
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic [pmwd_pkg::CELL_W-1:0]          o_cell_x,
    output logic [pmwd_pkg::CELL_W-1:0]          o_cell_y,
    output logic [pmwd_pkg::CELL_W-1:0]          o_cell_z,
    output logic [pmwd_pkg::WT_W-1:0]            o_cell_weight,
    output logic signed [pmwd_pkg::VAL_W-1:0]    o_contribution,
    output logic                                 o_last_cell,
    // Configuration write channel.
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [pmwd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [pmwd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import pmwd_pkg::*;

    // Front stages: input, mod, distance, minimum image, zone, square, weight.
    localparam int MOD_SPS    = 2;
    localparam int MOD_STAGES = (INT_W + MOD_SPS - 1) / MOD_SPS;
    localparam int FS_DIST    = MOD_STAGES + 1;
    localparam int FS_MIN     = FS_DIST + 1;
    localparam int FS_SQOP    = FS_MIN + 1;
    localparam int FS_PROD    = FS_SQOP + 1;
    localparam int FS_WT      = FS_PROD + 1;
    localparam int NF         = FS_WT + 1;
    localparam int NB         = 5;
    localparam int PER_W      = MESH_W + FRAC_BITS;
    localparam int PM_W       = VAL_W + WT_W;

    typedef struct packed {
        logic [2:0][INT_W-1:0]     rem;
        logic [2:0][FRAC_BITS-1:0] frac;
        logic [VAL_W-1:0]          mag;
        logic                      neg;
    } t_modst;

    typedef struct packed {
        logic [2:0][CELL_W-1:0]     start;
        logic [2:0][2:0][WT_W-1:0]  span;
        logic [VAL_W-1:0]           mag;
        logic                       neg;
    } t_dst;

    typedef struct packed {
        logic [2:0][CELL_W-1:0]     start;
        logic [2:0][2:0][WT_W-1:0]  span;
        logic [2:0][2:0][WT_W-1:0]  sqop;
        logic [2:0][2:0]            zero;
        logic [2:0][2:0]            mid;
        logic [VAL_W-1:0]           mag;
        logic                       neg;
    } t_sqst;

    typedef struct packed {
        logic [2:0][CELL_W-1:0]     start;
        logic [2:0][2:0][WT_W-1:0]  span;
        logic [2:0][2:0][PROD_W-1:0] prod;
        logic [2:0][2:0]            zero;
        logic [2:0][2:0]            mid;
        logic [VAL_W-1:0]           mag;
        logic                       neg;
    } t_prst;

    typedef struct packed {
        logic [2:0][CELL_W-1:0]     start;
        logic [2:0][2:0][WT_W-1:0]  w;
        logic [VAL_W-1:0]           mag;
        logic                       neg;
    } t_wst;

    typedef struct packed {
        logic [CELL_W-1:0] cx;
        logic [CELL_W-1:0] cy;
        logic [CELL_W-1:0] cz;
        logic [WT_W-1:0]   weight;
        logic              last;
        logic              neg;
    } t_cell;

    typedef struct packed {
        t_cell            info;
        logic [WT_W-1:0]  wx;
        logic [WT_W-1:0]  wy;
        logic [WT_W-1:0]  wz;
        logic [VAL_W-1:0] mag;
    } t_b0;

    typedef struct packed {
        t_cell            info;
        logic [WT_W-1:0]  xy;
        logic [WT_W-1:0]  wz;
        logic [VAL_W-1:0] mag;
    } t_b1;

    typedef struct packed {
        t_cell            info;
        logic [VAL_W-1:0] mag;
    } t_b2;

    typedef struct packed {
        t_cell            info;
        logic [VAL_W-1:0] val;
    } t_b3;

    // One restoring step of the integer reduction: subtract m << k if it fits.
    function automatic logic [INT_W-1:0] mod_step(input logic [INT_W-1:0]  r,
                                                  input logic [MESH_W-1:0] m,
                                                  input int                k);
        logic [MESH_W+INT_W-1:0] sh;
        sh = (MESH_W + INT_W)'(m) << k;
        if ((MESH_W + INT_W)'(r) >= sh) begin
            return r - sh[INT_W-1:0];
        end
        return r;
    endfunction

    // Stencil index plus offset, wrapped once into the mesh.
    function automatic logic [CELL_W-1:0] wrap_add(input logic [CELL_W-1:0] s,
                                                   input logic [PT_W-1:0]   a,
                                                   input logic [MESH_W-1:0] m);
        logic [MESH_W-1:0] sum;
        sum = MESH_W'(s) + MESH_W'(a);
        if (sum >= m) begin
            sum = sum - m;
        end
        return sum[CELL_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers. The mesh size is stored already clamped.
    // ------------------------------------------------------------------
    logic [MESH_W-1:0] r_mesh;
    logic              r_tsc;
    logic [MESH_W-1:0] n_mesh;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        priority if (i_cfg_data < CFG_DATA_W'(MESH_MIN)) begin
            n_mesh = MESH_W'(MESH_MIN);
        end else if (32'(i_cfg_data) > 32'(MAX_MESH)) begin
            n_mesh = MESH_W'(MAX_MESH);
        end else begin
            n_mesh = MESH_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mesh <= MESH_W'(MESH_RESET);
            r_tsc  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_MESH_SIZE: begin
                    r_mesh <= n_mesh;
                end
                REG_SCHEME_ORDER: begin
                    r_tsc <= (i_cfg_data[SCHEME_W-1:0] == SCHEME_TSC);
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Front pipeline: one particle per stage, elastic valid/ready chain.
    // ------------------------------------------------------------------
    logic [NF-1:0] r_fv;
    logic [NF:0]   f_rdy;
    logic          w_take;

    t_modst n_in;
    t_modst r_ms [MOD_STAGES+1];
    t_modst n_ms [MOD_STAGES+1];
    t_dst   r_ds, n_ds;
    t_dst   r_mi, n_mi;
    t_sqst  r_sq, n_sq;
    t_prst  r_pr, n_pr;
    t_wst   r_ws, n_ws;

    assign o_ready = f_rdy[0];

    always_comb begin
        f_rdy[NF] = w_take;
        for (int k = NF - 1; k >= 0; k--) begin
            f_rdy[k] = !r_fv[k] || f_rdy[k+1];
        end
    end

    // Input stage: split positions, take the magnitude of the value.
    always_comb begin
        logic [VAL_W-1:0] v;
        v = i_deposit_value;
        n_in.rem[0]  = i_pos_x[POS_W-1:FRAC_BITS];
        n_in.rem[1]  = i_pos_y[POS_W-1:FRAC_BITS];
        n_in.rem[2]  = i_pos_z[POS_W-1:FRAC_BITS];
        n_in.frac[0] = i_pos_x[FRAC_BITS-1:0];
        n_in.frac[1] = i_pos_y[FRAC_BITS-1:0];
        n_in.frac[2] = i_pos_z[FRAC_BITS-1:0];
        n_in.neg     = v[VAL_W-1];
        n_in.mag     = v[VAL_W-1] ? (~v) + VAL_W'(1) : v;
    end

    // Integer part mod mesh size, MOD_SPS restoring steps per stage.
    always_comb begin
        int k;
        n_ms[0] = n_in;
        for (int j = 0; j < MOD_STAGES; j++) begin
            n_ms[j+1] = r_ms[j];
            for (int ax = 0; ax < 3; ax++) begin
                for (int s = 0; s < MOD_SPS; s++) begin
                    k = INT_W - 1 - j * MOD_SPS - s;
                    if (k >= 0) begin
                        n_ms[j+1].rem[ax] = mod_step(n_ms[j+1].rem[ax], r_mesh, k);
                    end
                end
            end
        end
    end

    // Stencil start cell and raw distances per axis.
    always_comb begin
        logic [WT_W-1:0]   fe;
        logic [WT_W-1:0]   t;
        logic [CELL_W-1:0] ip;
        n_ds.mag = r_ms[MOD_STAGES].mag;
        n_ds.neg = r_ms[MOD_STAGES].neg;
        for (int ax = 0; ax < 3; ax++) begin
            fe = WT_W'(r_ms[MOD_STAGES].frac[ax]);
            ip = CELL_W'(r_ms[MOD_STAGES].rem[ax]);
            if (r_tsc) begin
                if (fe >= W_HALF) begin
                    n_ds.start[ax] = ip;
                    t = fe - W_HALF;
                end else begin
                    n_ds.start[ax] = (ip == '0) ? CELL_W'(r_mesh - MESH_W'(1))
                                                : ip - CELL_W'(1);
                    t = fe + W_HALF;
                end
                n_ds.span[ax][0] = W_HALF + t;
                n_ds.span[ax][1] = (t >= W_HALF) ? t - W_HALF : W_HALF - t;
                n_ds.span[ax][2] = W_THREE_HALF - t;
            end else begin
                t = '0;
                n_ds.start[ax]   = ip;
                n_ds.span[ax][0] = fe;
                n_ds.span[ax][1] = W_ONE - fe;
                n_ds.span[ax][2] = t;
            end
        end
    end

    // Periodic minimum image of every distance.
    always_comb begin
        logic [PER_W-1:0] period;
        logic [PER_W-1:0] d;
        logic [PER_W-1:0] other;
        n_mi   = r_ds;
        period = PER_W'(r_mesh) << FRAC_BITS;
        for (int ax = 0; ax < 3; ax++) begin
            for (int p = 0; p < NPTS; p++) begin
                d     = PER_W'(r_ds.span[ax][p]);
                other = (period > d) ? period - d : '0;
                if (other < d) begin
                    n_mi.span[ax][p] = WT_W'(other);
                end
            end
        end
    end

    // Weight zone and the operand to square.
    always_comb begin
        logic [WT_W-1:0] d;
        n_sq.start = r_mi.start;
        n_sq.span  = r_mi.span;
        n_sq.mag   = r_mi.mag;
        n_sq.neg   = r_mi.neg;
        for (int ax = 0; ax < 3; ax++) begin
            for (int p = 0; p < NPTS; p++) begin
                d = r_mi.span[ax][p];
                n_sq.zero[ax][p] = r_tsc ? (d > W_THREE_HALF) : (d > W_ONE);
                n_sq.mid[ax][p]  = r_tsc && (d > W_HALF);
                n_sq.sqop[ax][p] = (r_tsc && (d > W_HALF)) ? W_THREE_HALF - d : d;
            end
        end
    end

    // Squares, one multiplier per stencil point and axis.
    always_comb begin
        n_pr.start = r_sq.start;
        n_pr.span  = r_sq.span;
        n_pr.zero  = r_sq.zero;
        n_pr.mid   = r_sq.mid;
        n_pr.mag   = r_sq.mag;
        n_pr.neg   = r_sq.neg;
        for (int ax = 0; ax < 3; ax++) begin
            for (int p = 0; p < NPTS; p++) begin
                n_pr.prod[ax][p] = PROD_W'(r_sq.sqop[ax][p]) * PROD_W'(r_sq.sqop[ax][p]);
            end
        end
    end

    // Final axis weights in Q1.FRAC_BITS.
    always_comb begin
        logic [PROD_W-1:0] tail;
        logic [PROD_W-1:0] core;
        n_ws.start = r_pr.start;
        n_ws.mag   = r_pr.mag;
        n_ws.neg   = r_pr.neg;
        for (int ax = 0; ax < 3; ax++) begin
            for (int p = 0; p < NPTS; p++) begin
                tail = r_pr.prod[ax][p] >> (FRAC_BITS + 1);
                core = (TSC_PEAK - r_pr.prod[ax][p]) >> FRAC_BITS;
                if (r_pr.zero[ax][p]) begin
                    n_ws.w[ax][p] = '0;
                end else if (!r_tsc) begin
                    n_ws.w[ax][p] = W_ONE - r_pr.span[ax][p];
                end else if (r_pr.mid[ax][p]) begin
                    n_ws.w[ax][p] = WT_W'(tail);
                end else begin
                    n_ws.w[ax][p] = WT_W'(core);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else begin
            if (f_rdy[0]) begin
                r_fv[0] <= i_valid;
            end
            for (int k = 1; k < NF; k++) begin
                if (f_rdy[k]) begin
                    r_fv[k] <= r_fv[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j <= MOD_STAGES; j++) begin
            if (f_rdy[j]) begin
                r_ms[j] <= n_ms[j];
            end
        end
        if (f_rdy[FS_DIST]) begin
            r_ds <= n_ds;
        end
        if (f_rdy[FS_MIN]) begin
            r_mi <= n_mi;
        end
        if (f_rdy[FS_SQOP]) begin
            r_sq <= n_sq;
        end
        if (f_rdy[FS_PROD]) begin
            r_pr <= n_pr;
        end
        if (f_rdy[FS_WT]) begin
            r_ws <= n_ws;
        end
    end

    // ------------------------------------------------------------------
    // Stencil walker: holds one particle and hands out a cell per cycle while
    // the result pipeline accepts, z fastest, then y, then x.
    // ------------------------------------------------------------------
    logic            r_wv;
    t_wst            r_wk;
    logic [PT_W-1:0] r_ca, r_cb, r_cc;
    logic [PT_W-1:0] w_lim;
    logic            w_last;
    logic            w_emit;
    logic [NB:0]     b_rdy;

    assign w_lim  = r_tsc ? PT_W'(NPTS - 1) : PT_W'(1);
    assign w_last = (r_ca == w_lim) && (r_cb == w_lim) && (r_cc == w_lim);
    assign w_emit = r_wv && b_rdy[0];
    assign w_take = !r_wv || (w_emit && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= 1'b0;
            r_ca <= '0;
            r_cb <= '0;
            r_cc <= '0;
        end else if (w_take) begin
            r_wv <= r_fv[NF-1];
            r_ca <= '0;
            r_cb <= '0;
            r_cc <= '0;
        end else if (w_emit) begin
            if (r_cc == w_lim) begin
                r_cc <= '0;
                if (r_cb == w_lim) begin
                    r_cb <= '0;
                    r_ca <= r_ca + PT_W'(1);
                end else begin
                    r_cb <= r_cb + PT_W'(1);
                end
            end else begin
                r_cc <= r_cc + PT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_wk <= r_ws;
        end
    end

    // ------------------------------------------------------------------
    // Result pipeline: weight products, contribution and sign.
    // ------------------------------------------------------------------
    logic [NB-1:0] r_bv;
    t_b0           r_b0, n_b0;
    t_b1           r_b1, n_b1;
    t_b2           r_b2, n_b2;
    t_b3           r_b3, n_b3;
    t_b3           r_b4, n_b4;

    always_comb begin
        b_rdy[NB] = i_ready;
        for (int k = NB - 1; k >= 0; k--) begin
            b_rdy[k] = !r_bv[k] || b_rdy[k+1];
        end
    end

    always_comb begin
        n_b0.info.cx     = wrap_add(r_wk.start[0], r_ca, r_mesh);
        n_b0.info.cy     = wrap_add(r_wk.start[1], r_cb, r_mesh);
        n_b0.info.cz     = wrap_add(r_wk.start[2], r_cc, r_mesh);
        n_b0.info.weight = '0;
        n_b0.info.last   = w_last;
        n_b0.info.neg    = r_wk.neg;
        n_b0.wx          = r_wk.w[0][r_ca];
        n_b0.wy          = r_wk.w[1][r_cb];
        n_b0.wz          = r_wk.w[2][r_cc];
        n_b0.mag         = r_wk.mag;
    end

    always_comb begin
        logic [PROD_W-1:0] pxy;
        pxy       = PROD_W'(r_b0.wx) * PROD_W'(r_b0.wy);
        n_b1.info = r_b0.info;
        n_b1.xy   = pxy[FRAC_BITS+WT_W-1:FRAC_BITS];
        n_b1.wz   = r_b0.wz;
        n_b1.mag  = r_b0.mag;
    end

    always_comb begin
        logic [PROD_W-1:0] pw;
        pw               = PROD_W'(r_b1.xy) * PROD_W'(r_b1.wz);
        n_b2.info        = r_b1.info;
        n_b2.info.weight = pw[FRAC_BITS+WT_W-1:FRAC_BITS];
        n_b2.mag         = r_b1.mag;
    end

    always_comb begin
        logic [PM_W-1:0] pm;
        pm        = PM_W'(r_b2.mag) * PM_W'(r_b2.info.weight);
        n_b3.info = r_b2.info;
        n_b3.val  = pm[FRAC_BITS+VAL_W-1:FRAC_BITS];
    end

    always_comb begin
        n_b4.info = r_b3.info;
        n_b4.val  = r_b3.info.neg ? (~r_b3.val) + VAL_W'(1) : r_b3.val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else begin
            if (b_rdy[0]) begin
                r_bv[0] <= r_wv;
            end
            for (int k = 1; k < NB; k++) begin
                if (b_rdy[k]) begin
                    r_bv[k] <= r_bv[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_rdy[0]) begin
            r_b0 <= n_b0;
        end
        if (b_rdy[1]) begin
            r_b1 <= n_b1;
        end
        if (b_rdy[2]) begin
            r_b2 <= n_b2;
        end
        if (b_rdy[3]) begin
            r_b3 <= n_b3;
        end
        if (b_rdy[4]) begin
            r_b4 <= n_b4;
        end
    end

    assign o_valid        = r_bv[NB-1];
    assign o_cell_x       = r_b4.info.cx;
    assign o_cell_y       = r_b4.info.cy;
    assign o_cell_z       = r_b4.info.cz;
    assign o_cell_weight  = r_b4.info.weight;
    assign o_contribution = r_b4.val;
    assign o_last_cell    = r_b4.info.last;

endmodule

`default_nettype wire

@@ design/pmwd_checker.sv @@
// ============================================================================
// pmwd_checker: port checker for the particle mesh weight deposit
// Watches the result channel of the top level and is bound to it.
// ============================================================================
`default_nettype none

module pmwd_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               o_valid,
    input wire                               i_ready,
    input wire [pmwd_pkg::CELL_W-1:0]        o_cell_x,
    input wire [pmwd_pkg::CELL_W-1:0]        o_cell_y,
    input wire [pmwd_pkg::CELL_W-1:0]        o_cell_z,
    input wire [pmwd_pkg::WT_W-1:0]          o_cell_weight,
    input wire signed [pmwd_pkg::VAL_W-1:0]  o_contribution,
    input wire                               o_last_cell
);
    import pmwd_pkg::*;

    // A stalled result transfer keeps its cell and values.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable({o_cell_x, o_cell_y, o_cell_z,
            o_cell_weight, o_contribution, o_last_cell}))
        else $error("result changed while stalled");

    // The product of three axis weights never exceeds one.
    a_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_cell_weight <= W_ONE)
        else $error("cell weight above one");

    // A cell of zero weight receives nothing.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_cell_weight == '0) |-> o_contribution == '0)
        else $error("nonzero contribution at zero weight");

    // Reset empties the result pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind particle_mesh_weight_deposit pmwd_checker u_pmwd_checker (.*);

`default_nettype wire
